>>> src/scalar_mod_order_alu_assert.svh
// assertion macros used by the scalar order alu top level
// expects clk and rst_n in the scope where a macro is used
`ifndef SCALAR_MOD_ORDER_ALU_ASSERT_SVH
`define SCALAR_MOD_ORDER_ALU_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SOM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("som assertion failed");

// condition holds in the cycle after the trigger
`define SOM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("som assertion failed");

`endif

>>> src/som_pkg.sv
// types and constants for the scalar order alu
// no dependencies
package som_pkg;

    localparam int LIMB_W  = 64;
    localparam int SCAL_W  = 256;
    localparam int DIGIT_W = 32;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_RED = 3'd3,
        OP_NEG = 3'd4
    } op_t;

    // group order m = 2^255 - FOLD_C
    localparam logic [SCAL_W-1:0] ORDER_M = {
        64'h7FFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
        64'hEB2483E3AAA540D4, 64'hFA4CE1A52B3B8F24
    };

    localparam logic [127:0] FOLD_C = 128'h14DB7C1C555ABF2B05B31E5AD4C470DC;

endpackage

>>> src/scalar_mod_order_alu.sv
// top level of the scalar order alu: add, sub, negate when odd (even passes), multiply and wide reduce mod m
// depends on som_pkg, som_mul and scalar_mod_order_alu_assert.svh
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | operation, a_limb0..a_limb3, b_limb0..b_limb3
//  out     | out_valid/out_ready | result_limb0..result_limb3
//
// one transfer per cycle in each direction while out_ready holds; the depth is set by the
// 256x256 product (9 stages) and two folds by 2^255 = c mod m (10 and 5 stages)
// rst_n clears only the stage valid bits
// each stage moves when empty or when the stage after it moves, so bubbles
// close up behind a stalled output and nothing is dropped or repeated
module scalar_mod_order_alu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [63:0] a_limb0,
    input  logic [63:0] a_limb1,
    input  logic [63:0] a_limb2,
    input  logic [63:0] a_limb3,
    input  logic [63:0] b_limb0,
    input  logic [63:0] b_limb1,
    input  logic [63:0] b_limb2,
    input  logic [63:0] b_limb3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_limb0,
    output logic [63:0] result_limb1,
    output logic [63:0] result_limb2,
    output logic [63:0] result_limb3
);

`include "scalar_mod_order_alu_assert.svh"

    localparam int SW = som_pkg::SCAL_W;

    // stage ready chain
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, s6_ready;
    logic s7_ready, s8_ready, s9_ready;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg, s9_valid_reg;

    som_pkg::op_t op1_reg, op2_reg, op3_reg, op4_reg, op5_reg, op6_reg;
    som_pkg::op_t op7_reg, op8_reg, op9_reg;

    logic [SW-1:0] a1_reg, b1_reg, a2_reg, b2_reg, a3_reg, b3_reg, a4_reg, b4_reg;
    logic [SW-1:0] x2_next, y2_next, x2_reg, y2_reg;
    logic          even2_next, even2_reg, even3_reg;
    logic [SW-1:0] sum3_reg;
    logic [SW:0]   diff3;
    logic [SW-1:0] addres3;
    logic [2*SW-1:0] early4_next, early4_reg;

    // full product path
    logic            m1_in_ready, m1_out_valid;
    logic [2*SW-1:0] m1_prod;
    logic [2*SW-1:0] m1_early;
    som_pkg::op_t    m1_op;
    logic [2*SW-1:0] x5;
    logic [256:0]    hi5_reg;
    logic [254:0]    lo5_reg;
    logic [SW-1:0]   byp5_reg, byp6_reg, byp7_reg, byp8_reg;

    // first fold
    logic            f1_in_ready, f1_out_valid;
    logic [415:0]    f1_prod;
    logic [254:0]    f1_lo;
    logic [SW-1:0]   f1_byp;
    som_pkg::op_t    f1_op;
    logic [382:0]    v1_sum;
    logic [127:0]    hi6_reg;
    logic [254:0]    lo6_reg;

    // second fold
    logic            f2_in_ready, f2_out_valid;
    logic [SW-1:0]   f2_prod;
    logic [254:0]    f2_lo;
    logic [SW-1:0]   f2_byp;
    som_pkg::op_t    f2_op;
    logic [SW:0]     v2_sum;
    logic [SW-1:0]   v7_reg, v8_reg;
    logic [SW-1:0]   v3_next;
    logic [SW:0]     diff8;
    logic [SW-1:0]   red8;
    logic [SW-1:0]   res9_next, res9_reg;
    logic            wide8;

    assign s9_ready = !s9_valid_reg || out_ready;
    assign s8_ready = !s8_valid_reg || s9_ready;
    assign s7_ready = !s7_valid_reg || s8_ready;
    assign s6_ready = !s6_valid_reg || f2_in_ready;
    assign s5_ready = !s5_valid_reg || f1_in_ready;
    assign s4_ready = !s4_valid_reg || m1_in_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
            if (s5_ready) s5_valid_reg <= m1_out_valid;
            if (s6_ready) s6_valid_reg <= f1_out_valid;
            if (s7_ready) s7_valid_reg <= f2_out_valid;
            if (s8_ready) s8_valid_reg <= s7_valid_reg;
            if (s9_ready) s9_valid_reg <= s8_valid_reg;
        end
    end

    // second operand of the modular add: b, m - b or m - a
    always_comb
    begin
        x2_next    = a1_reg;
        y2_next    = b1_reg;
        even2_next = 1'b0;
        case (op1_reg)
            som_pkg::OP_SUB:
            begin
                y2_next = som_pkg::ORDER_M - b1_reg;
            end
            som_pkg::OP_NEG:
            begin
                x2_next    = '0;
                y2_next    = som_pkg::ORDER_M - a1_reg;
                even2_next = !a1_reg[0];
            end
            default:
            begin
                y2_next = b1_reg;
            end
        endcase
    end

    // conditional subtract of m, then the wide value for the reduction path
    assign diff3   = {1'b0, sum3_reg} - {1'b0, som_pkg::ORDER_M};
    assign addres3 = diff3[SW] ? sum3_reg : diff3[SW-1:0];

    always_comb
    begin
        case (op3_reg)
            som_pkg::OP_ADD,
            som_pkg::OP_SUB: early4_next = {{SW{1'b0}}, addres3};
            som_pkg::OP_NEG: early4_next = {{SW{1'b0}}, even3_reg ? a3_reg : addres3};
            som_pkg::OP_RED: early4_next = {b3_reg, a3_reg};
            default:         early4_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            op1_reg <= som_pkg::op_t'(operation);
            a1_reg  <= {a_limb3, a_limb2, a_limb1, a_limb0};
            b1_reg  <= {b_limb3, b_limb2, b_limb1, b_limb0};
        end
        if (s2_ready)
        begin
            op2_reg   <= op1_reg;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            x2_reg    <= x2_next;
            y2_reg    <= y2_next;
            even2_reg <= even2_next;
        end
        if (s3_ready)
        begin
            op3_reg   <= op2_reg;
            a3_reg    <= a2_reg;
            b3_reg    <= b2_reg;
            sum3_reg  <= x2_reg + y2_reg;
            even3_reg <= even2_reg;
        end
        if (s4_ready)
        begin
            op4_reg    <= op3_reg;
            a4_reg     <= a3_reg;
            b4_reg     <= b3_reg;
            early4_reg <= early4_next;
        end
    end

    som_mul #(
        .A_DIGITS (8),
        .B_DIGITS (8),
        .SIDE_W   (3 + 2*SW)
    ) u_mul_full (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .in_ready  (m1_in_ready),
        .a         (a4_reg),
        .b         (b4_reg),
        .side_in   ({op4_reg, early4_reg}),
        .out_valid (m1_out_valid),
        .out_ready (s5_ready),
        .prod      (m1_prod),
        .side_out  ({m1_op, m1_early})
    );

    // x = hi * 2^255 + lo, and 2^255 = c mod m
    assign x5 = (m1_op == som_pkg::OP_MUL) ? m1_prod : m1_early;

    always_ff @(posedge clk)
    begin
        if (s5_ready)
        begin
            op5_reg  <= m1_op;
            hi5_reg  <= x5[511:255];
            lo5_reg  <= x5[254:0];
            byp5_reg <= m1_early[SW-1:0];
        end
    end

    som_mul #(
        .A_DIGITS (9),
        .B_DIGITS (4),
        .SIDE_W   (3 + 255 + SW)
    ) u_mul_fold1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .in_ready  (f1_in_ready),
        .a         ({31'd0, hi5_reg}),
        .b         (som_pkg::FOLD_C),
        .side_in   ({op5_reg, lo5_reg, byp5_reg}),
        .out_valid (f1_out_valid),
        .out_ready (s6_ready),
        .prod      (f1_prod),
        .side_out  ({f1_op, f1_lo, f1_byp})
    );

    assign v1_sum = {1'b0, f1_prod[381:0]} + {128'd0, f1_lo};

    always_ff @(posedge clk)
    begin
        if (s6_ready)
        begin
            op6_reg  <= f1_op;
            hi6_reg  <= v1_sum[382:255];
            lo6_reg  <= v1_sum[254:0];
            byp6_reg <= f1_byp;
        end
    end

    som_mul #(
        .A_DIGITS (4),
        .B_DIGITS (4),
        .SIDE_W   (3 + 255 + SW)
    ) u_mul_fold2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_valid_reg),
        .in_ready  (f2_in_ready),
        .a         (hi6_reg),
        .b         (som_pkg::FOLD_C),
        .side_in   ({op6_reg, lo6_reg, byp6_reg}),
        .out_valid (f2_out_valid),
        .out_ready (s7_ready),
        .prod      (f2_prod),
        .side_out  ({f2_op, f2_lo, f2_byp})
    );

    assign v2_sum  = {1'b0, f2_prod} + {2'b0, f2_lo};
    // last fold of the top bit keeps the value below 2m
    assign v3_next = {1'b0, v7_reg[254:0]} + (v7_reg[255] ? {128'd0, som_pkg::FOLD_C} : '0);

    assign diff8 = {1'b0, v8_reg} - {1'b0, som_pkg::ORDER_M};
    assign red8  = diff8[SW] ? v8_reg : diff8[SW-1:0];
    assign wide8 = (op8_reg == som_pkg::OP_MUL) || (op8_reg == som_pkg::OP_RED);
    assign res9_next = wide8 ? red8 : byp8_reg;

    always_ff @(posedge clk)
    begin
        if (s7_ready)
        begin
            op7_reg  <= f2_op;
            v7_reg   <= v2_sum[SW-1:0];
            byp7_reg <= f2_byp;
        end
        if (s8_ready)
        begin
            op8_reg  <= op7_reg;
            v8_reg   <= v3_next;
            byp8_reg <= byp7_reg;
        end
        if (s9_ready)
        begin
            op9_reg  <= op8_reg;
            res9_reg <= res9_next;
        end
    end

    assign out_valid    = s9_valid_reg;
    assign result_limb0 = res9_reg[63:0];
    assign result_limb1 = res9_reg[127:64];
    assign result_limb2 = res9_reg[191:128];
    assign result_limb3 = res9_reg[255:192];

    `SOM_ASSERT_NEXT(a_in_load, in_valid && in_ready, s1_valid_reg)
    `SOM_ASSERT_NOW(a_fold2_fits, f2_out_valid && s7_ready, !v2_sum[SW])
    `SOM_ASSERT_NOW(a_fold3_below_2m, s8_valid_reg, {1'b0, v8_reg} < {som_pkg::ORDER_M, 1'b0})
    `SOM_ASSERT_NOW(a_result_reduced, s9_valid_reg && ((op9_reg == som_pkg::OP_MUL) || (op9_reg == som_pkg::OP_RED)), res9_reg < som_pkg::ORDER_M)

endmodule

>>> src/som_mul.sv
// pipelined wide multiplier built from 32x32 partial products
// one row of partial products is accumulated per stage; depends on som_pkg
module som_mul #(
    parameter int A_DIGITS = 8,
    parameter int B_DIGITS = 8,
    parameter int SIDE_W   = 8
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [som_pkg::DIGIT_W*A_DIGITS-1:0]          a,
    input  logic [som_pkg::DIGIT_W*B_DIGITS-1:0]          b,
    input  logic [SIDE_W-1:0]                             side_in,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [som_pkg::DIGIT_W*(A_DIGITS+B_DIGITS)-1:0] prod,
    output logic [SIDE_W-1:0]                             side_out
);

    localparam int DW = som_pkg::DIGIT_W;
    localparam int PW = DW * (A_DIGITS + B_DIGITS);
    localparam int NS = A_DIGITS + 1;

    logic [2*DW-1:0] pp_reg   [NS][A_DIGITS][B_DIGITS];
    logic [PW-1:0]   acc_reg  [NS];
    logic [SIDE_W-1:0] side_reg [NS];
    logic [NS-1:0]   valid_reg;
    logic [NS-1:0]   stg_ready;
    logic [PW-1:0]   row_e    [NS];
    logic [PW-1:0]   row_o    [NS];
    logic [PW-1:0]   acc_next [NS];

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        stg_ready[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int s = NS - 2; s >= 0; s--)
        begin
            stg_ready[s] = !valid_reg[s] || stg_ready[s+1];
        end
    end

    // even and odd columns of one row do not overlap
    always_comb
    begin
        row_e[0]    = '0;
        row_o[0]    = '0;
        acc_next[0] = '0;
        for (int s = 1; s < NS; s++)
        begin
            row_e[s] = '0;
            row_o[s] = '0;
            for (int j = 0; j < B_DIGITS; j++)
            begin
                if (j[0] == 1'b0)
                begin
                    row_e[s][DW*(s-1+j) +: 2*DW] = pp_reg[s-1][s-1][j];
                end
                else
                begin
                    row_o[s][DW*(s-1+j) +: 2*DW] = pp_reg[s-1][s-1][j];
                end
            end
            acc_next[s] = acc_reg[s-1] + row_e[s] + row_o[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stg_ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (stg_ready[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready[0])
        begin
            for (int i = 0; i < A_DIGITS; i++)
            begin
                for (int j = 0; j < B_DIGITS; j++)
                begin
                    pp_reg[0][i][j] <= (2*DW)'(a[DW*i +: DW]) * (2*DW)'(b[DW*j +: DW]);
                end
            end
            acc_reg[0]  <= '0;
            side_reg[0] <= side_in;
        end
        for (int s = 1; s < NS; s++)
        begin
            if (stg_ready[s])
            begin
                pp_reg[s]   <= pp_reg[s-1];
                acc_reg[s]  <= acc_next[s];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign in_ready  = stg_ready[0];
    assign out_valid = valid_reg[NS-1];
    assign prod      = acc_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule

>>> bench/scalar_mod_order_alu_tb.sv
// testbench for the scalar order alu: directed corners, then random traffic
// predicts every result with wide integer arithmetic; depends on som_pkg and the rtl
`timescale 1ns / 100ps

class order_alu_scoreboard;
    logic [255:0] pending_results[$];
    int           mismatch_count;

    function logic [255:0] add_mod(logic [255:0] x, logic [255:0] y);
        logic [255:0] s;
        s = x + y;
        return (s >= som_pkg::ORDER_M) ? s - som_pkg::ORDER_M : s;
    endfunction

    function void note_operation(logic [2:0] op, logic [255:0] a, logic [255:0] b);
        logic [511:0] wide;
        logic [255:0] r;
        r = '0;
        case (op)
            som_pkg::OP_ADD: r = add_mod(a, b);
            som_pkg::OP_SUB: r = add_mod(a, som_pkg::ORDER_M - b);
            som_pkg::OP_MUL:
            begin
                wide = {256'd0, a} * {256'd0, b};
                wide = wide % {256'd0, som_pkg::ORDER_M};
                r = wide[255:0];
            end
            som_pkg::OP_RED:
            begin
                wide = {b, a} % {256'd0, som_pkg::ORDER_M};
                r = wide[255:0];
            end
            som_pkg::OP_NEG: r = a[0] ? add_mod('0, som_pkg::ORDER_M - a) : a;
            default: r = '0;
        endcase
        pending_results.push_back(r);
    endfunction

    function void check_result(logic [255:0] got);
        logic [255:0] want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: result %h with nothing pending", $time, got);
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        for (int i = 0; i < 4; i++)
            if (want[64*i +: 64] !== got[64*i +: 64])
            begin
                $display("%0t: result_limb%0d expected %h actual %h",
                         $time, i, want[64*i +: 64], got[64*i +: 64]);
                mismatch_count++;
            end
    endfunction
endclass

module scalar_mod_order_alu_tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  operation;
    logic [63:0] a_limb0, a_limb1, a_limb2, a_limb3;
    logic [63:0] b_limb0, b_limb1, b_limb2, b_limb3;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] result_limb0, result_limb1, result_limb2, result_limb3;

    order_alu_scoreboard scoreboard = new();
    int  accepted_count;
    int  cycle_count;
    bit  hold_done;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [255:0] ALL_ONES = '1;

    scalar_mod_order_alu DUT (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function int gap_cycles(bit busy);
        int r;
        if (busy)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [255:0] random_scalar();
        logic [255:0] v;
        for (int i = 0; i < 8; i++)
            v[32*i +: 32] = $urandom;
        return v;
    endfunction

    // operands mostly below m, with some extremes and unrestricted values
    function logic [255:0] random_operand();
        case ($urandom_range(0, 9))
            0: return som_pkg::ORDER_M - $urandom_range(1, 3);
            1: return ALL_ONES;
            2: return $urandom_range(0, 3);
            3: return random_scalar();
            default: return random_scalar() % som_pkg::ORDER_M;
        endcase
    endfunction

    task automatic send_operation(logic [2:0] op, logic [255:0] a, logic [255:0] b, bit busy);
        int gap;
        gap = gap_cycles(busy);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        {a_limb3, a_limb2, a_limb1, a_limb0} <= a;
        {b_limb3, b_limb2, b_limb1, b_limb0} <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    // transfer accounting on both channels
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            scoreboard.note_operation(operation, {a_limb3, a_limb2, a_limb1, a_limb0},
                                      {b_limb3, b_limb2, b_limb1, b_limb0});
            accepted_count++;
        end
        if (rst_n && out_valid && out_ready)
            scoreboard.check_result({result_limb3, result_limb2, result_limb1, result_limb0});
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, one long hold once the pipe has traffic
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            if (!hold_done && accepted_count >= 40)
            begin
                hold_done = 1;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            stall = ($urandom_range(0, 3) == 0) ? gap_cycles(0) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        logic [2:0] op;
        bit busy;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = som_pkg::OP_ADD;
        {a_limb3, a_limb2, a_limb1, a_limb0} = '0;
        {b_limb3, b_limb2, b_limb1, b_limb0} = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners: zeros, values just below m, all ones, odd and even negate, unused codes
        send_operation(som_pkg::OP_ADD, '0, '0, 0);
        send_operation(som_pkg::OP_ADD, som_pkg::ORDER_M - 1, som_pkg::ORDER_M - 1, 0);
        send_operation(som_pkg::OP_ADD, som_pkg::ORDER_M - 1, 256'd1, 0);
        send_operation(som_pkg::OP_ADD, ALL_ONES, ALL_ONES, 0);
        send_operation(som_pkg::OP_SUB, '0, '0, 0);
        send_operation(som_pkg::OP_SUB, '0, som_pkg::ORDER_M - 1, 0);
        send_operation(som_pkg::OP_SUB, ALL_ONES, ALL_ONES, 0);
        send_operation(som_pkg::OP_MUL, som_pkg::ORDER_M - 1, som_pkg::ORDER_M - 1, 0);
        send_operation(som_pkg::OP_MUL, ALL_ONES, ALL_ONES, 0);
        send_operation(som_pkg::OP_MUL, '0, ALL_ONES, 0);
        send_operation(som_pkg::OP_RED, ALL_ONES, ALL_ONES, 0);
        send_operation(som_pkg::OP_RED, som_pkg::ORDER_M, '0, 0);
        send_operation(som_pkg::OP_RED, '0, '0, 0);
        send_operation(som_pkg::OP_NEG, 256'd1, '0, 0);
        send_operation(som_pkg::OP_NEG, som_pkg::ORDER_M - 2, '0, 0);
        send_operation(som_pkg::OP_NEG, 256'd2, '0, 0);
        send_operation(som_pkg::OP_NEG, ALL_ONES, '0, 0);
        send_operation(som_pkg::OP_NEG, ALL_ONES - 1, '0, 0);
        send_operation(3'd5, ALL_ONES, ALL_ONES, 0);
        send_operation(3'd6, ALL_ONES, ALL_ONES, 0);
        send_operation(3'd7, ALL_ONES, ALL_ONES, 0);

        for (int n = 0; n < 830; n++)
        begin
            // alternate stretches of back-to-back transfers with gappy ones
            busy = ((n / 64) % 3) == 1;
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            send_operation(op, random_operand(), random_operand(), busy);
        end
        in_valid <= 1'b0;

        while (scoreboard.pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (scoreboard.mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/som_pkg.sv
src/som_mul.sv
src/scalar_mod_order_alu.sv
bench/scalar_mod_order_alu_tb.sv
